// ===== src/assert_macros.svh =====
// Assertion macros shared by the timer RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SRT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== src/srt_pkg.sv =====
// Shared codes and types of the stimulus-response timer.
package srt_pkg;

    // Request opcodes.
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_STIM = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Stimulus modes; the unused code toggles and arms a reversal.
    localparam logic [1:0] SMODE_UP   = 2'd0;
    localparam logic [1:0] SMODE_DOWN = 2'd1;
    localparam logic [1:0] SMODE_FLIP = 2'd2;

    // Wanted response modes.
    localparam logic [1:0] RMODE_MATCH  = 2'd0;
    localparam logic [1:0] RMODE_INVERT = 2'd1;
    localparam logic [1:0] RMODE_HIGH   = 2'd2;
    localparam logic [1:0] RMODE_LOW    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STIM_MODE      = 2'd0;
    localparam logic [1:0] CFG_RESP_MODE      = 2'd1;
    localparam logic [1:0] CFG_RESET_DURATION = 2'd2;

    localparam int CFG_DATA_W = 16;
    localparam int LAT_W      = 32;

    // Current configuration.
    typedef struct packed {
        logic [1:0]            stim_mode;
        logic [1:0]            resp_mode;
        logic [CFG_DATA_W-1:0] reset_duration;
    } srt_cfg_t;

    // One result of a request.
    typedef struct packed {
        logic             drive_level;
        logic             accepted;
        logic             response_seen;
        logic [LAT_W-1:0] latency;
    } srt_result_t;

endpackage

// ===== src/stimulus_response_timer.sv =====
// Top level of the stimulus-response timer.
// Each request (tick with a sampled input level, stimulus, or read) gives
// exactly one result, so the block accepts one request per clock while in_ready
// is high. All the work for a request is a single pass through the timer state
// to a result register, backed by a one-deep skid register, so in_ready only
// drops after two results wait untaken. Configuration is written through
// cfg_write, cfg_addr and cfg_data (index 0 stimulus mode, 1 response mode, 2
// revert duration in ticks); the user must write it only while no request is
// in flight, which the block does not enforce. Timestamps are TIME_BITS wide;
// the latency reported is the low 32 bits of their difference.
module stimulus_response_timer
    import srt_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            opcode,
    input  logic                  input_level,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  drive_level,
    output logic                  accepted,
    output logic                  response_seen,
    output logic [LAT_W-1:0]      latency
);

    srt_cfg_t    cfg;
    srt_result_t core_result;
    srt_result_t out_data;
    logic        item_fire;

    assign item_fire = in_valid && in_ready;

    // Configuration registers.
    srt_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Timer state and request processing.
    srt_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item_fire   (item_fire),
        .opcode      (opcode),
        .input_level (input_level),
        .result      (core_result)
    );

    // Result register and skid stage.
    srt_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_fire),
        .push_data (core_result),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign drive_level   = out_data.drive_level;
    assign accepted      = out_data.accepted;
    assign response_seen = out_data.response_seen;
    assign latency       = out_data.latency;

endmodule

// ===== src/srt_cfg_regs.sv =====
// Configuration register file of the timer.
module srt_cfg_regs
    import srt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output srt_cfg_t              cfg
);

    srt_cfg_t cfg_reg;
    srt_cfg_t cfg_next;

    // Decode the register index; writes beyond the list are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_addr)
                CFG_STIM_MODE:      cfg_next.stim_mode = cfg_data[1:0];
                CFG_RESP_MODE:      cfg_next.resp_mode = cfg_data[1:0];
                CFG_RESET_DURATION: cfg_next.reset_duration = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/srt_core.sv =====
// Timer state and the single-pass update that turns one request into one result.
`include "assert_macros.svh"
module srt_core
    import srt_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  srt_cfg_t    cfg,
    input  logic        item_fire,
    input  logic [1:0]  opcode,
    input  logic        input_level,
    output srt_result_t result
);

    localparam int DIFF_W = (TIME_BITS > LAT_W) ? TIME_BITS : LAT_W;

    logic [TIME_BITS-1:0] tick_reg, tick_next;
    logic                 out_reg, out_next;
    logic                 wanted_reg, wanted_next;
    logic                 seen_reg, seen_next;
    logic [TIME_BITS-1:0] stim_time_reg, stim_time_next;
    logic [TIME_BITS-1:0] resp_time_reg, resp_time_next;
    logic                 pend_reg, pend_next;
    // Holds the tick count at which the reversal fires (deadline plus one).
    logic [TIME_BITS-1:0] fire_at_reg, fire_at_next;

    logic                 stim_ok;
    logic                 stim_level;
    logic                 stim_wanted;
    logic                 stim_take;
    logic [DIFF_W-1:0]    time_diff;

    // A rise is refused at a high output and a fall at a low one.
    assign stim_ok = !((cfg.stim_mode == SMODE_UP) && out_reg)
                  && !((cfg.stim_mode == SMODE_DOWN) && !out_reg);

    // A stimulus request is taken in this cycle.
    assign stim_take = item_fire && (opcode == OP_STIM);

    // Output level after an accepted stimulus.
    always_comb
    begin
        case (cfg.stim_mode)
            SMODE_UP:   stim_level = 1'b1;
            SMODE_DOWN: stim_level = 1'b0;
            default:    stim_level = !out_reg;
        endcase
    end

    // Response level to wait for after that stimulus.
    always_comb
    begin
        case (cfg.resp_mode)
            RMODE_MATCH:  stim_wanted = stim_level;
            RMODE_INVERT: stim_wanted = !stim_level;
            RMODE_HIGH:   stim_wanted = 1'b1;
            default:      stim_wanted = 1'b0;
        endcase
    end

    // State update for the request being accepted.
    always_comb
    begin
        tick_next      = tick_reg;
        out_next       = out_reg;
        wanted_next    = wanted_reg;
        seen_next      = seen_reg;
        stim_time_next = stim_time_reg;
        resp_time_next = resp_time_reg;
        pend_next      = pend_reg;
        fire_at_next   = fire_at_reg;
        case (opcode)
            OP_TICK:
            begin
                if (!seen_reg && (input_level == wanted_reg))
                begin
                    resp_time_next = tick_reg;
                    seen_next      = 1'b1;
                end
                if (pend_reg && (tick_reg == fire_at_reg))
                begin
                    pend_next = 1'b0;
                    out_next  = !out_reg;
                end
                tick_next = tick_reg + 1'b1;
            end
            OP_STIM:
            begin
                if (stim_ok)
                begin
                    out_next       = stim_level;
                    wanted_next    = stim_wanted;
                    seen_next      = 1'b0;
                    stim_time_next = tick_reg;
                    if (cfg.stim_mode != SMODE_FLIP)
                    begin
                        pend_next    = 1'b1;
                        fire_at_next = tick_reg + TIME_BITS'(cfg.reset_duration)
                                     + TIME_BITS'(1);
                    end
                end
            end
            default:
            begin
                tick_next = tick_reg;
            end
        endcase
    end

    // Latency is the low bits of the zero-extended timestamp difference.
    assign time_diff = DIFF_W'(resp_time_reg) - DIFF_W'(stim_time_reg);

    // Result fields as they stand after the request.
    always_comb
    begin
        result.drive_level   = out_next;
        result.accepted      = (opcode == OP_STIM) && stim_ok;
        result.response_seen = seen_next;
        result.latency       = ((opcode == OP_READ) && seen_reg)
                             ? time_diff[LAT_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            out_reg       <= 1'b0;
            wanted_reg    <= 1'b0;
            seen_reg      <= 1'b0;
            stim_time_reg <= '0;
            resp_time_reg <= '0;
            pend_reg      <= 1'b0;
            fire_at_reg   <= '0;
        end
        else if (item_fire)
        begin
            tick_reg      <= tick_next;
            out_reg       <= out_next;
            wanted_reg    <= wanted_next;
            seen_reg      <= seen_next;
            stim_time_reg <= stim_time_next;
            resp_time_reg <= resp_time_next;
            pend_reg      <= pend_next;
            fire_at_reg   <= fire_at_next;
        end
    end

    // An accepted rise always leaves the output high.
    `SRT_ASSERT_NEXT(a_rise_drives_high, stim_take && (cfg.stim_mode == SMODE_UP) && !out_reg, out_reg)
    // Only a stimulus request can clear the seen flag.
    `SRT_ASSERT_NEXT(a_seen_holds, seen_reg && !stim_take, seen_reg)

endmodule

// ===== src/srt_out_buf.sv =====
// Two-entry result buffer: output register plus skid register.
`include "assert_macros.svh"
module srt_out_buf
    import srt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  srt_result_t push_data,
    output logic        can_push,
    output logic        out_valid,
    input  logic        out_ready,
    output srt_result_t out_data
);

    logic        main_valid_reg;
    logic        skid_valid_reg;
    srt_result_t main_reg;
    srt_result_t skid_reg;
    logic        pop;

    assign pop      = main_valid_reg && out_ready;
    assign can_push = !skid_valid_reg;

    // Valid flags: the skid entry only fills while the output is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            main_valid_reg <= 1'b1;
            skid_valid_reg <= main_valid_reg;
        end
    end

    // Payload registers follow the same order.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // The skid entry is never occupied ahead of the output register.
    `SRT_ASSERT_IMPL(a_skid_needs_main, skid_valid_reg, main_valid_reg)
    // A taken result always drains the skid entry.
    `SRT_ASSERT_NEXT(a_skid_drains, skid_valid_reg && out_ready, !skid_valid_reg)

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the stimulus-response timer.
`timescale 1ns / 1ps

module tb
    import srt_pkg::*;
();

    localparam int TIME_BITS   = 32;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 50;

    // Codes the package leaves unnamed.
    localparam logic [1:0] OP_NONE          = 2'd3;
    localparam logic [1:0] SMODE_FLIP_ARMED = 2'd3;
    localparam logic [1:0] CFG_UNUSED       = 2'd3;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_write   = 1'b0;
    logic [1:0]            cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [1:0]            opcode      = '0;
    logic                  input_level = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic                  drive_level;
    logic                  accepted;
    logic                  response_seen;
    logic [LAT_W-1:0]      latency;

    // Timer state as the testbench expects it.
    logic [TIME_BITS-1:0]  now_tick      = '0;
    logic                  pin_level     = 1'b0;
    logic                  target_level  = 1'b0;
    logic                  got_response  = 1'b0;
    logic [TIME_BITS-1:0]  t_stim        = '0;
    logic [TIME_BITS-1:0]  t_resp        = '0;
    logic                  revert_armed  = 1'b0;
    logic [TIME_BITS-1:0]  revert_at     = '0;
    logic [1:0]            cur_stim_mode = SMODE_UP;
    logic [1:0]            cur_resp_mode = RMODE_MATCH;
    logic [CFG_DATA_W-1:0] cur_duration  = '0;

    srt_result_t result_q[$];

    int  n_sent       = 0;
    int  n_checked    = 0;
    int  n_errors     = 0;
    int  n_fired      = 0;
    int  n_refused    = 0;
    int  n_reversals  = 0;
    int  n_latched    = 0;
    int  n_configs    = 0;
    int  quiet_cycles = 0;
    bit  no_idle      = 1'b0;
    bit  hold_request = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stimulus_response_timer #(
        .TIME_BITS (TIME_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .input_level   (input_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drive_level   (drive_level),
        .accepted      (accepted),
        .response_seen (response_seen),
        .latency       (latency)
    );

    // Apply one request to the expected timer state and return its result.
    function automatic srt_result_t predict_request(logic [1:0] op, logic lvl);
        srt_result_t          res;
        logic [TIME_BITS-1:0] fire_at;
        logic [TIME_BITS-1:0] diff;
        res = '0;
        fire_at = revert_at + 1'b1;
        case (op)
            OP_TICK:
            begin
                // Sample first, then the reversal, then the counter advances.
                if (!got_response && lvl == target_level)
                begin
                    t_resp = now_tick;
                    got_response = 1'b1;
                    n_latched++;
                end
                if (revert_armed && now_tick == fire_at)
                begin
                    revert_armed = 1'b0;
                    pin_level = ~pin_level;
                    n_reversals++;
                end
                now_tick = now_tick + 1'b1;
            end
            OP_STIM:
            begin
                if ((cur_stim_mode == SMODE_UP && pin_level) ||
                    (cur_stim_mode == SMODE_DOWN && !pin_level))
                begin
                    n_refused++;
                end
                else
                begin
                    case (cur_stim_mode)
                        SMODE_UP:   pin_level = 1'b1;
                        SMODE_DOWN: pin_level = 1'b0;
                        default:    pin_level = ~pin_level;
                    endcase
                    case (cur_resp_mode)
                        RMODE_MATCH:  target_level = pin_level;
                        RMODE_INVERT: target_level = ~pin_level;
                        RMODE_HIGH:   target_level = 1'b1;
                        default:      target_level = 1'b0;
                    endcase
                    got_response = 1'b0;
                    t_stim = now_tick;
                    // A plain toggle neither arms nor cancels a reversal.
                    if (cur_stim_mode != SMODE_FLIP)
                    begin
                        revert_at = now_tick + cur_duration;
                        revert_armed = 1'b1;
                    end
                    res.accepted = 1'b1;
                    n_fired++;
                end
            end
            OP_READ:
            begin
                if (got_response)
                begin
                    diff = t_resp - t_stim;
                    res.latency = LAT_W'(diff);
                end
            end
            default:
            begin
            end
        endcase
        res.drive_level = pin_level;
        res.response_seen = got_response;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [LAT_W-1:0] want,
                               input logic [LAT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Track configuration writes and requests, and check every result taken.
    always @(posedge clk)
    begin
        srt_result_t want;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_addr)
                    CFG_STIM_MODE:      cur_stim_mode = cfg_data[1:0];
                    CFG_RESP_MODE:      cur_resp_mode = cfg_data[1:0];
                    CFG_RESET_DURATION: cur_duration = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
                result_q.push_back(predict_request(opcode, input_level));
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: result with no request waiting: drive %b acc %b seen %b lat %0h",
                             $time, drive_level, accepted, response_seen, latency);
                    n_errors++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("drive_level", want.drive_level, drive_level);
                    check_field("accepted", want.accepted, accepted);
                    check_field("response_seen", want.response_seen, response_seen);
                    check_field("latency", want.latency, latency);
                end
                n_checked++;
            end
        end
    end

    // Result side: random stalls per result, plus a long hold-off on request.
    initial
    begin : receiver
        int stall;
        int hold_left;
        stall = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (out_valid && out_ready && !no_idle)
                stall = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Stop the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: errors");
            $finish;
        end
    end

    // Offer one request after a random gap and return at the edge that takes it.
    task automatic send_req(input logic [1:0] op, input logic lvl);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        input_level <= lvl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_sent++;
    endtask

    // Stop offering requests and wait until every result is back.
    task automatic drain();
        in_valid <= 1'b0;
        while (n_checked != n_sent)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // One register write; the caller lowers cfg_write after the last one.
    task automatic write_reg(input logic [1:0] addr, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Wait for idle, then write all three registers; dirty sets unused upper bits.
    task automatic set_config(input logic [1:0] smode, input logic [1:0] rmode,
                              input logic [CFG_DATA_W-1:0] dur, input bit dirty);
        logic [CFG_DATA_W-1:0] upper;
        drain();
        upper = dirty ? CFG_DATA_W'($urandom()) & ~CFG_DATA_W'(3) : '0;
        write_reg(CFG_STIM_MODE, upper | CFG_DATA_W'(smode));
        write_reg(CFG_RESP_MODE, upper | CFG_DATA_W'(rmode));
        write_reg(CFG_RESET_DURATION, dur);
        cfg_write <= 1'b0;
        n_configs++;
    endtask

    // Reset defaults, refusals, zero latency, reversal timing and odd codes.
    task automatic test_directed();
        // Defaults after reset: rise, same level, no delay.
        send_req(OP_READ, 1'b0);
        send_req(OP_NONE, 1'b1);
        send_req(OP_TICK, 1'b1);
        send_req(OP_TICK, 1'b0);
        send_req(OP_READ, 1'b1);

        // Second rise is refused; a match on the next tick reads latency zero.
        set_config(SMODE_UP, RMODE_MATCH, '0, 1'b0);
        send_req(OP_STIM, 1'b0);
        send_req(OP_STIM, 1'b1);
        send_req(OP_TICK, 1'b1);
        send_req(OP_TICK, 1'b0);
        send_req(OP_READ, 1'b0);

        // A toggle leaves the reversal armed by the rise before it.
        set_config(SMODE_UP, RMODE_HIGH, 16'd2, 1'b0);
        send_req(OP_STIM, 1'b0);
        set_config(SMODE_FLIP, RMODE_INVERT, 16'hFFFF, 1'b0);
        send_req(OP_STIM, 1'b1);
        repeat (4) send_req(OP_TICK, 1'b1);
        send_req(OP_READ, 1'b0);

        // Fall with a one-tick delay.
        set_config(SMODE_DOWN, RMODE_LOW, 16'd1, 1'b0);
        send_req(OP_STIM, 1'b0);
        send_req(OP_TICK, 1'b1);
        send_req(OP_TICK, 1'b0);
        send_req(OP_TICK, 1'b0);
        send_req(OP_READ, 1'b1);

        // The unused stimulus mode toggles and still arms a reversal.
        set_config(SMODE_FLIP_ARMED, RMODE_MATCH, '0, 1'b0);
        send_req(OP_STIM, 1'b1);
        send_req(OP_TICK, 1'b0);
        send_req(OP_TICK, 1'b1);
        send_req(OP_READ, 1'b0);

        // A write to the unused index changes nothing.
        drain();
        write_reg(CFG_UNUSED, 16'hFFFF);
        cfg_write <= 1'b0;
    endtask

    // Hold the result side long enough that the block stops taking requests.
    task automatic test_backpressure();
        drain();
        hold_request = 1'b1;
        no_idle = 1'b1;
        repeat (24)
            send_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        no_idle = 1'b0;
        drain();
    endtask

    // A stimulus, a run of ticks with biased levels and a read, with noise.
    task automatic run_measurement();
        int ticks;
        int bias;
        if ($urandom_range(0, 5) == 0)
            send_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        send_req(OP_STIM, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0)
            send_req(OP_STIM, 1'($urandom_range(0, 1)));
        ticks = $urandom_range(0, 12);
        bias = $urandom_range(0, 8);
        for (int i = 0; i < ticks; i++)
        begin
            send_req(OP_TICK, 1'($urandom_range(0, 7) < bias));
            if ($urandom_range(0, 9) == 0)
                send_req(OP_READ, 1'($urandom_range(0, 1)));
        end
        send_req(OP_READ, 1'($urandom_range(0, 1)));
    endtask

    // Phases of random measurements under changing settings.
    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] dur;
        int                    start;
        for (int ph = 0; ph < 24; ph++)
        begin
            case ($urandom_range(0, 4))
                0:       dur = '0;
                1:       dur = 16'hFFFF;
                2:       dur = CFG_DATA_W'($urandom());
                default: dur = CFG_DATA_W'($urandom_range(0, 10));
            endcase
            if (ph == 0)
                set_config(SMODE_UP, RMODE_MATCH, '0, 1'b0);
            else if (ph == 1)
                set_config(SMODE_FLIP_ARMED, RMODE_LOW, 16'hFFFF, 1'b1);
            else
                set_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), dur,
                           1'($urandom_range(0, 1)));
            no_idle = (ph % 4 == 3);
            start = n_sent;
            while (n_sent - start < 50)
                run_measurement();
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_phases();

        drain();
        if (result_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, result_q.size());
            n_errors++;
        end

        $display("Checked %0d results over %0d settings; %0d stimuli fired, %0d refused.",
                 n_checked, n_configs, n_fired, n_refused);
        $display("Saw %0d automatic reversals and %0d latched responses; %0d mismatches.",
                 n_reversals, n_latched, n_errors);
        if (n_errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/srt_pkg.sv
src/srt_cfg_regs.sv
src/srt_core.sv
src/srt_out_buf.sv
src/stimulus_response_timer.sv
verif/tb.sv
